FILE: rtl/core/cmpc_pkg.sv
package cmpc_pkg;

	typedef logic [1:0] cause_t;

	localparam cause_t CAUSE_NONE      = 2'd0;
	localparam cause_t CAUSE_MISMATCH  = 2'd1;
	localparam cause_t CAUSE_OVERFLOW  = 2'd2;
	localparam cause_t CAUSE_NO_MARKER = 2'd3;

	localparam logic [7:0] CENTER_RESET = 8'd99;

	typedef struct packed {
		logic   accepted;
		cause_t cause;
	} verdict_t;

endpackage

FILE: rtl/core/center_marked_palindrome_check_top.sv
// channel   | handshake              | payload
// ----------+------------------------+---------------------------
// in        | in_valid / in_stall    | symbol[7:0], last_symbol
// out       | out_valid / out_stall  | accepted, reject_cause[1:0]
// cfg       | cfg_wr_en              | cfg_wr_data[7:0] (center_symbol)
//
// one beat per cycle unless in_stall; a verdict is registered from its last beat
// the stack lives in a one-port-write, one-port-read memory of STACK_DEPTH bytes;
// the top entry is re-read every cycle at the next count, with a bypass after a push
// arst_n clears count, flags and the output stages; the memory is not cleared
// a two-entry output stage (register plus skid) keeps input flowing while out is stalled;
// in_stall rises only when both entries hold verdicts
module center_marked_palindrome_check_top #(
	parameter int STACK_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	input  logic       last_symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       accepted,
	output logic [1:0] reject_cause
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] ONE  = CW'(1);

	logic [7:0]    center_q;
	logic [CW-1:0] count_q;
	logic          after_q;
	logic          mismatch_q;
	logic          overflow_q;

	logic [7:0]    mem [STACK_DEPTH];
	logic [7:0]    rd_q;
	logic [7:0]    fwd_q;
	logic          use_fwd_q;

	logic          skid_full_q;
	cmpc_pkg::verdict_t out_q;
	cmpc_pkg::verdict_t skid_q;

	logic          in_acc;
	logic [7:0]    tos;
	logic          is_mark;
	logic          full;
	logic          push;
	logic          pop;
	logic          ovf_hit;
	logic          mis_hit;
	logic          after_n;
	logic          mismatch_n;
	logic          overflow_n;
	logic [CW-1:0] cnt_step;
	logic [CW-1:0] cnt_next;
	logic [CW-1:0] rd_cnt;
	logic [CW-1:0] rd_cnt_m1;
	logic [AW-1:0] raddr;
	logic          res_valid;
	cmpc_pkg::verdict_t res;

	assign in_stall = skid_full_q;
	assign in_acc   = in_valid && !in_stall;
	assign tos      = use_fwd_q ? fwd_q : rd_q;
	assign is_mark  = (symbol == center_q);
	assign full     = (count_q == FULL);

	always_comb begin
		push    = !after_q && !is_mark && !full;
		ovf_hit = !after_q && !is_mark && full;
		pop     = after_q && (count_q != '0) && (tos == symbol);
		mis_hit = after_q && !pop;

		if (push) begin
			cnt_step = count_q + ONE;
		end else if (pop) begin
			cnt_step = count_q - ONE;
		end else begin
			cnt_step = count_q;
		end

		after_n    = after_q || is_mark;
		mismatch_n = mismatch_q || mis_hit;
		overflow_n = overflow_q || ovf_hit;

		if (overflow_n) begin
			res.cause = cmpc_pkg::CAUSE_OVERFLOW;
		end else if (!after_n) begin
			res.cause = cmpc_pkg::CAUSE_NO_MARKER;
		end else if (mismatch_n || (cnt_step != '0)) begin
			res.cause = cmpc_pkg::CAUSE_MISMATCH;
		end else begin
			res.cause = cmpc_pkg::CAUSE_NONE;
		end
		res.accepted = (res.cause == cmpc_pkg::CAUSE_NONE);

		cnt_next  = last_symbol ? '0 : cnt_step;
		rd_cnt    = in_acc ? cnt_next : count_q;
		rd_cnt_m1 = rd_cnt - ONE;
		raddr     = rd_cnt_m1[AW-1:0];
		res_valid = in_acc && last_symbol;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= cmpc_pkg::CENTER_RESET;
		end else if (cfg_wr_en) begin
			center_q <= cfg_wr_data;
		end
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			after_q    <= 1'b0;
			mismatch_q <= 1'b0;
			overflow_q <= 1'b0;
			use_fwd_q  <= 1'b0;
		end else begin
			use_fwd_q <= in_acc && push;
			if (in_acc) begin
				count_q    <= cnt_next;
				after_q    <= after_n && !last_symbol;
				mismatch_q <= mismatch_n && !last_symbol;
				overflow_q <= overflow_n && !last_symbol;
			end
		end
	end

	// stack memory, top re-read every cycle
	always_ff @(posedge clk) begin
		if (in_acc && push) begin
			mem[count_q[AW-1:0]] <= symbol;
		end
		rd_q  <= mem[raddr];
		fwd_q <= symbol;
	end

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (!out_stall) begin
				skid_full_q <= 1'b0;
			end
		end else if (out_valid && out_stall) begin
			if (res_valid) begin
				skid_full_q <= 1'b1;
			end
		end else begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (!out_stall) begin
				out_q <= skid_q;
			end
		end else if (out_valid && out_stall) begin
			if (res_valid) begin
				skid_q <= res;
			end
		end else if (res_valid) begin
			out_q <= res;
		end
	end

	assign accepted     = out_q.accepted;
	assign reject_cause = out_q.cause;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid)
		else $error("skid holds a verdict while out is empty");

	a_verdict_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accepted == (reject_cause == cmpc_pkg::CAUSE_NONE)))
		else $error("accepted disagrees with reject_cause");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("stack count beyond depth");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_symbol) |=> (count_q == '0 && !after_q && !mismatch_q && !overflow_q))
		else $error("string state not cleared after last beat");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int STACK_DEPTH = 64;
	localparam int LONG_HOLD   = 200;
	localparam int SETTLE      = 6;

	typedef logic [7:0] beat_q_t [$];

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] symbol      = 8'd0;
	logic       last_symbol = 1'b0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic       accepted;
	logic [1:0] reject_cause;

	// mirror of the recognizer state
	logic [7:0] mirror_stack [STACK_DEPTH];
	int         mirror_depth       = 0;
	logic       mirror_past_center = 1'b0;
	logic       mirror_mismatch    = 1'b0;
	logic       mirror_overflow    = 1'b0;
	logic [7:0] mirror_center      = cmpc_pkg::CENTER_RESET;
	cmpc_pkg::verdict_t verdicts_due [$];

	bit tx_idle_on  = 1'b1;
	bit rx_idle_on  = 1'b1;
	int hold_req    = 0;
	int hold_served = 0;
	int hold_left   = 0;

	int errors             = 0;
	int beats_sent         = 0;
	int strings_sent       = 0;
	int verdicts_seen      = 0;
	int centers_written    = 0;
	int input_stall_cycles = 0;

	center_marked_palindrome_check_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.symbol      (symbol),
		.last_symbol (last_symbol),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.accepted    (accepted),
		.reject_cause(reject_cause)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic track_beat(input logic [7:0] s, input logic l);
		cmpc_pkg::verdict_t v;
		if (!mirror_past_center) begin
			if (s == mirror_center) begin
				mirror_past_center = 1'b1;
			end else if (mirror_depth < STACK_DEPTH) begin
				mirror_stack[mirror_depth] = s;
				mirror_depth++;
			end else begin
				mirror_overflow = 1'b1;
			end
		end else if (mirror_depth == 0) begin
			mirror_mismatch = 1'b1;
		end else if (mirror_stack[mirror_depth - 1] == s) begin
			mirror_depth--;
		end else begin
			mirror_mismatch = 1'b1;
		end
		if (l) begin
			if (mirror_overflow)
				v.cause = cmpc_pkg::CAUSE_OVERFLOW;
			else if (!mirror_past_center)
				v.cause = cmpc_pkg::CAUSE_NO_MARKER;
			else if (mirror_mismatch || mirror_depth != 0)
				v.cause = cmpc_pkg::CAUSE_MISMATCH;
			else
				v.cause = cmpc_pkg::CAUSE_NONE;
			v.accepted = (v.cause == cmpc_pkg::CAUSE_NONE);
			verdicts_due.push_back(v);
			mirror_depth       = 0;
			mirror_past_center = 1'b0;
			mirror_mismatch    = 1'b0;
			mirror_overflow    = 1'b0;
		end
	endtask

	task automatic send_beat(input logic [7:0] s, input logic l);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		symbol      <= s;
		last_symbol <= l;
		do @(posedge clk); while (in_stall);
		track_beat(s, l);
		beats_sent++;
	endtask

	task automatic send_string(input beat_q_t str);
		for (int i = 0; i < str.size(); i++)
			send_beat(str[i], i == str.size() - 1);
		strings_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_center(input logic [7:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mirror_center = v;
		centers_written++;
		@(posedge clk);
	endtask

	function automatic beat_q_t from_text(input string t);
		beat_q_t q;
		for (int i = 0; i < t.len(); i++)
			q.push_back(t[i]);
		return q;
	endfunction

	function automatic beat_q_t random_stem(input int n);
		beat_q_t    q;
		logic [7:0] b;
		repeat (n) begin
			do b = 8'($urandom); while (b == mirror_center);
			q.push_back(b);
		end
		return q;
	endfunction

	function automatic beat_q_t palindrome(input beat_q_t stem, input bit with_center);
		beat_q_t q;
		q = stem;
		if (with_center)
			q.push_back(mirror_center);
		for (int k = stem.size() - 1; k >= 0; k--)
			q.push_back(stem[k]);
		return q;
	endfunction

	task automatic send_random_string();
		beat_q_t str, stem;
		int      len, kind, k;
		kind = $urandom_range(0, 11);
		if ($urandom_range(0, 19) == 0)
			len = $urandom_range(56, 68);
		else
			len = $urandom_range(0, 10);
		stem = random_stem(len);
		str  = palindrome(stem, kind != 10);
		case (kind)
			7: begin
				if (stem.size() != 0) begin
					k = $urandom_range(stem.size() + 1, str.size() - 1);
					str[k] = mirror_center;
				end
			end
			8: begin
				if (stem.size() != 0) begin
					k = $urandom_range(stem.size() + 1, str.size() - 1);
					str[k] = str[k] ^ 8'($urandom_range(1, 255));
				end
			end
			9: begin
				if ($urandom_range(0, 1) == 1)
					str.push_back(8'($urandom));
				else if (stem.size() != 0)
					void'(str.pop_back());
			end
			10: begin
				if (str.size() == 0)
					str = random_stem(1);
			end
			11: begin
				str.delete();
				repeat ($urandom_range(1, 12)) begin
					if ($urandom_range(0, 3) == 0)
						str.push_back(mirror_center);
					else
						str.push_back(8'($urandom));
				end
			end
			default: ;
		endcase
		send_string(str);
	endtask

	task automatic test_directed_strings();
		send_string(from_text("c"));
		send_string(from_text("abcba"));
		send_string(from_text("abcab"));
		send_string(from_text("abc"));
		send_string(from_text("ab"));
		send_string(from_text("acaa"));
		send_string(from_text("cc"));
		send_string(from_text("abcaba"));
		send_string('{8'h00, 8'hFF, cmpc_pkg::CENTER_RESET, 8'hFF, 8'h00});
		send_string('{8'hFF});
		wait_idle();
	endtask

	task automatic test_full_stack();
		beat_q_t stem;
		stem = random_stem(STACK_DEPTH);
		send_string(palindrome(stem, 1'b1));
		stem = random_stem(STACK_DEPTH + 1);
		send_string(palindrome(stem, 1'b1));
		stem = random_stem(STACK_DEPTH + 6);
		send_string(stem);
		wait_idle();
	endtask

	task automatic test_center_extremes();
		write_center(8'h00);
		send_string('{8'h01, 8'hFF, 8'h00, 8'hFF, 8'h01});
		send_string('{8'h00});
		send_string('{8'h00, 8'h00});
		wait_idle();
		write_center(8'hFF);
		send_string('{8'h00, 8'hFF, 8'h00});
		send_string('{8'hFF});
		send_string('{8'h7F, 8'h80, 8'hFF, 8'h80, 8'h01});
		wait_idle();
	endtask

	task automatic test_back_pressure();
		tx_idle_on = 1'b0;
		hold_req <= hold_req + 1;
		for (int i = 0; i < 24; i++) begin
			if (i % 2 == 0)
				send_string('{mirror_center});
			else
				send_string(random_stem(1));
		end
		wait_idle();
		tx_idle_on = 1'b1;
	endtask

	task automatic test_random_phase(input logic [7:0] center, input int n,
		input bit idle_on);
		int goal;
		write_center(center);
		tx_idle_on = idle_on;
		rx_idle_on <= idle_on;
		goal = beats_sent + n;
		while (beats_sent < goal)
			send_random_string();
		wait_idle();
	endtask

	// receiver: random stall bursts, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_served) begin
			hold_served <= hold_req;
			hold_left   <= LONG_HOLD - 1;
			out_stall   <= 1'b1;
		end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
			hold_left <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cmpc_pkg::verdict_t want;
		if (in_valid && in_stall)
			input_stall_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected verdict: accepted=%0b cause=%0d",
						accepted, reject_cause);
			end else begin
				want = verdicts_due.pop_front();
				verdicts_seen++;
				if (accepted !== want.accepted || reject_cause !== want.cause) begin
					errors++;
					if (errors <= 10)
						$display({"verdict %0d mismatch: expected accepted=%0b cause=%0d,",
							" got accepted=%0b cause=%0d"},
							verdicts_seen, want.accepted, want.cause,
							accepted, reject_cause);
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_strings();
		test_full_stack();
		test_center_extremes();
		test_back_pressure();
		test_random_phase(8'h00, 130, 1'b1);
		test_random_phase(8'hFF, 130, 1'b1);
		test_random_phase(8'($urandom_range(1, 254)), 130, 1'b1);
		test_random_phase(cmpc_pkg::CENTER_RESET, 130, 1'b0);
		wait_idle();
		if (verdicts_due.size() != 0)
			errors++;
		$display("covered %0d strings in %0d symbols, %0d verdicts checked, %0d errors",
			strings_sent, beats_sent, verdicts_seen, errors);
		$display("center code rewritten %0d times, input held off %0d cycles by back pressure",
			centers_written, input_stall_cycles);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
